[design/assert_macros.svh]
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/dvru_pkg.sv]
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvru_pkg;
  localparam int unsigned DefTableEntries = 64;
  localparam logic [4:0] MetricInf = 5'd16;

  typedef enum logic [1:0] {
    MODE_ROUTE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_REFRESH = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_ADD     = 3'd3,
    ACT_DELETE  = 3'd4,
    ACT_DROP    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DECIDE,
    ST_READ,
    ST_DONE
  } state_e;

  localparam logic REG_HOST = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  function automatic logic [15:0] ticks_remaining(logic [31:0] deadline, logic [31:0] now);
    logic [31:0] d;
    d = deadline - now;
    if (d == 32'd0 || d[31]) return 16'd0;
    if (d > 32'h0000_FFFF) return 16'hFFFF;
    return d[15:0];
  endfunction
endpackage

[design/dvru_table.sv]
// ----------------------------------------------------------------------------
// dvru_table
// Route store: one write port, one registered read port, valid flags.
// ----------------------------------------------------------------------------
module dvru_table #(
  parameter int unsigned Entries = 64,
  parameter int unsigned IdxW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [132:0]     wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [132:0]     rdata_o,
  output logic             rvalid_o
);
  logic [132:0] mem [Entries];
  logic [Entries-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_o <= 1'b0;
    end else begin
      if (we_i) valid_q[waddr_i] <= 1'b1;
      rvalid_o <= valid_q[raddr_i] && !(we_i && waddr_i == raddr_i);
    end
  end
endmodule

[design/distance_vector_route_update.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_update
// Distance-vector route table with a sequential slot scanner.
// ----------------------------------------------------------------------------
//  channel  | signals                               | handshake
//  item in  | start_i, mode_i .. read_index_i       | start_i & !busy_o
//  result   | done_o, trigger_update_o .. entry_*_o | done_o, one cycle
//  config   | psel/penable/pwrite/paddr/pwdata      | APB, pready high
// A route item scans the slots one by one through the one registered read
// port (SCAN, then CHECK, per slot) until a match or the table end,
// then DECIDE, READ and DONE; ticks, unused modes to DONE, reads via READ.
// busy_o drops in the result cycle, so the next item can be accepted there.
// Reset empties the table at once through valid flags; no clearing pass.
// Results cannot be stalled.
module distance_vector_route_update
  import dvru_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = dvru_pkg::DefTableEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] dest_addr_i,
  input  logic [31:0] dest_mask_i,
  input  logic [4:0]  adv_metric_i,
  input  logic [31:0] src_addr_i,
  input  logic        last_entry_i,
  input  logic [5:0]  read_index_i,
  output logic        done_o,
  output logic        trigger_update_o,
  output logic [2:0]  action_o,
  output logic [5:0]  entry_index_o,
  output logic [7:0]  message_changes_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_dest_o,
  output logic [31:0] entry_mask_o,
  output logic [31:0] entry_next_hop_o,
  output logic [4:0]  entry_metric_o,
  output logic [15:0] entry_time_left_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;

  `include "assert_macros.svh"

  state_e st_q, st_d;
  logic [31:0] host_q, now_q;
  logic [15:0] tmo_q;
  logic [7:0] chg_q;
  logic [1:0] mode_q;
  logic [31:0] dest_q, mask_q, src_q;
  logic [4:0] met_q;
  logic last_q;
  logic [5:0] ridx_q;
  logic [CntW-1:0] cnt_q;
  logic hit_q, free_q;
  logic [IdxW-1:0] hidx_q, fidx_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [132:0] wdata, rdata;
  logic rvalid;
  logic [31:0] r_dest, r_mask, r_hop, r_dl;
  logic [4:0] r_met;

  assign {r_dest, r_mask, r_hop, r_met, r_dl} = rdata;

  dvru_table #(.Entries(TABLE_ENTRIES), .IdxW(IdxW)) u_table (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata), .rvalid_o(rvalid)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, tmo_q} : host_q;
  assign busy_o = (st_q != ST_IDLE);

  logic [4:0] met_in;
  always_comb begin
    met_in = (adv_metric_i > MetricInf) ? MetricInf : adv_metric_i;
    if (src_addr_i != host_q && met_in < MetricInf) met_in = met_in + 5'd1;
  end

  logic scan_end;
  assign scan_end = (cnt_q == CntW'(TABLE_ENTRIES));
  assign raddr = (st_q == ST_IDLE) ? IdxW'(read_index_i) :
                 (st_q == ST_READ) ? IdxW'(ridx_q) :
                 (st_q == ST_DECIDE) ? hidx_q : cnt_q[IdxW-1:0];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (start_i) begin
        unique case (mode_e'(mode_i))
          MODE_ROUTE: st_d = ST_SCAN;
          MODE_READ:  st_d = ST_READ;
          default:    st_d = ST_DONE;
        endcase
      end
      ST_SCAN:   st_d = (scan_end || hit_q) ? ST_DECIDE : ST_CHECK;
      ST_CHECK:  st_d = ST_SCAN;
      ST_DECIDE: st_d = ST_READ;
      ST_READ:   st_d = ST_DONE;
      ST_DONE:   st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  logic [31:0] fresh;
  logic [15:0] tl;
  logic [2:0] act;
  logic trig, wr;
  logic [31:0] wdl;
  assign fresh = now_q + {16'd0, tmo_q};
  assign tl = ticks_remaining(r_dl, now_q);

  always_comb begin
    act = ACT_NONE; trig = 1'b0; wr = 1'b0; wdl = fresh;
    if (hit_q) begin
      if (r_hop == src_q) begin
        if (r_met != met_q) begin
          wr = 1'b1; trig = 1'b1;
          if (met_q == MetricInf) begin act = ACT_DELETE; wdl = now_q; end
          else act = ACT_REPLACE;
        end else begin
          wr = 1'b1;
          if (met_q != MetricInf) act = ACT_REFRESH;
          else begin act = ACT_DELETE; wdl = now_q; end
        end
      end else if (r_met > met_q) begin
        wr = 1'b1; act = ACT_REPLACE; trig = 1'b1;
      end else if (r_met == met_q && tl <= (tmo_q >> 1)) begin
        wr = 1'b1; act = ACT_REPLACE;
      end
    end else if (met_q < MetricInf) begin
      if (free_q) begin wr = 1'b1; act = ACT_ADD; trig = 1'b1; end
      else act = ACT_DROP;
    end
  end

  assign we = (st_q == ST_DECIDE) && wr;
  assign waddr = hit_q ? hidx_q : fidx_q;
  assign wdata = (hit_q && act == ACT_REFRESH) || (hit_q && act == ACT_DELETE
                  && r_met == met_q) ?
                 {r_dest, r_mask, r_hop, r_met, wdl} :
                 {dest_q, mask_q, src_q, met_q, wdl};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; host_q <= '0; tmo_q <= 16'd180; now_q <= '0; chg_q <= '0;
      cnt_q <= '0; hit_q <= 1'b0; free_q <= 1'b0; done_o <= 1'b0;
      hidx_q <= '0; fidx_q <= '0;
      trigger_update_o <= 1'b0; action_o <= ACT_NONE;
      entry_index_o <= '0; message_changes_o <= '0;
    end else begin
      st_q <= st_d;
      done_o <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_HOST) host_q <= pwdata;
        else tmo_q <= pwdata[15:0];
      end
      unique case (st_q)
        ST_IDLE: if (start_i) begin
          cnt_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
        end
        ST_CHECK: begin
          if (rvalid && r_dest == dest_q) begin
            hit_q <= 1'b1; hidx_q <= cnt_q[IdxW-1:0];
          end else if (!rvalid && !free_q) begin
            free_q <= 1'b1; fidx_q <= cnt_q[IdxW-1:0];
          end
          if (!(rvalid && r_dest == dest_q)) cnt_q <= cnt_q + CntW'(1);
        end
        ST_DECIDE: begin
          trigger_update_o <= trig;
          action_o <= act;
          entry_index_o <= (act == ACT_NONE || act == ACT_DROP) ? 6'd0 :
                           6'(waddr);
          if (trig && chg_q != 8'hFF) chg_q <= chg_q + 8'd1;
        end
        ST_READ: ;
        ST_DONE: begin
          done_o <= 1'b1;
          if (mode_q == MODE_ROUTE) begin
            message_changes_o <= chg_q;
            if (last_q) chg_q <= '0;
          end else begin
            message_changes_o <= chg_q;
            trigger_update_o <= 1'b0;
            action_o <= ACT_NONE;
            entry_index_o <= (mode_q == MODE_READ) ? ridx_q : 6'd0;
            if (mode_q == MODE_TICK) now_q <= now_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  logic rd_ok;
  assign rd_ok = rvalid && ({26'd0, ridx_q} < 32'(TABLE_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start_i) begin
      mode_q <= mode_i; dest_q <= dest_addr_i; mask_q <= dest_mask_i;
      src_q <= src_addr_i; met_q <= met_in; last_q <= last_entry_i;
      ridx_q <= read_index_i;
    end
    if (st_q == ST_DONE) begin
      entry_valid_o     <= 1'b0;
      entry_dest_o      <= '0;
      entry_mask_o      <= '0;
      entry_next_hop_o  <= '0;
      entry_metric_o    <= '0;
      entry_time_left_o <= '0;
      if (mode_q == MODE_READ && rd_ok) begin
        entry_valid_o     <= 1'b1;
        entry_dest_o      <= r_dest;
        entry_mask_o      <= r_mask;
        entry_next_hop_o  <= r_hop;
        entry_metric_o    <= r_met;
        entry_time_left_o <= tl;
      end
    end
  end

  `ASSERT_IMPL(a_busy_on_done, done_o, !busy_o)
  `ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `ASSERT_IMPL(a_we_decide, we, st_q == ST_DECIDE)
endmodule
